/* design/jse_pkg.sv */
// Shared widths and character codes for the JSON string escaper.
// No dependencies; compiled first.
package jse_pkg;

	localparam int BYTE_W  = 8;
	localparam int MAX_OUT = 8;                  // quote + six-byte escape + quote
	localparam int IDX_W   = $clog2(MAX_OUT);

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [IDX_W-1:0]  idx_t;

	localparam byte_t CHR_QUOTE  = 8'h22;
	localparam byte_t CHR_BSLASH = 8'h5C;
	localparam byte_t CHR_ZERO   = 8'h30;
	localparam byte_t CHR_UPPER_A = 8'h41;
	localparam byte_t CHR_LC_U   = 8'h75;
	localparam byte_t CHR_LC_B   = 8'h62;
	localparam byte_t CHR_LC_T   = 8'h74;
	localparam byte_t CHR_LC_N   = 8'h6E;
	localparam byte_t CHR_LC_F   = 8'h66;
	localparam byte_t CHR_LC_R   = 8'h72;

	localparam byte_t CTL_BS = 8'h08;
	localparam byte_t CTL_HT = 8'h09;
	localparam byte_t CTL_LF = 8'h0A;
	localparam byte_t CTL_FF = 8'h0C;
	localparam byte_t CTL_CR = 8'h0D;

	localparam byte_t PRINT_LO = 8'h20;
	localparam byte_t PRINT_HI = 8'h7E;

endpackage

/* design/jse_if.sv */
// Valid/ready channel interfaces for raw input beats and escaped output beats.
// Depends on jse_pkg.
interface jse_in_if;
	logic               valid;
	logic               ready;
	jse_pkg::byte_t     raw_byte;
	logic               string_start;
	logic               string_end;
	logic               string_empty;

	modport source (output valid, raw_byte, string_start, string_end, string_empty,
		input ready);
	modport sink (input valid, raw_byte, string_start, string_end, string_empty,
		output ready);
endinterface

interface jse_out_if;
	logic               valid;
	logic               ready;
	jse_pkg::byte_t     out_byte;
	logic               run_last;

	modport source (output valid, out_byte, run_last, input ready);
	modport sink (input valid, out_byte, run_last, output ready);
endinterface

/* design/json_string_escaper.sv */
// JSON string escaper top level: expands each raw byte into its escaped text.
// Depends on jse_pkg and the channel interfaces in jse_if.sv.
//
//  channel | dir | payload                                         | beat
//  --------+-----+-------------------------------------------------+------------------------
//  raw     | in  | raw_byte[7:0] string_start string_end string_empty | one string byte
//  text    | out | out_byte[7:0] run_last                          | one escaped text byte
//
// An accepted beat is expanded in one go into a stage-1 buffer of up to
// eight bytes; stage 1 then hands one byte per cycle to the output register
// while text is not stalled, so plain printable text flows at one beat per
// cycle; escapes hold raw.ready low while their extra bytes drain.
// Reset clears only the two stage valid flags; the data buffers need none.
// A stall on text freezes the output register; stage 1 keeps one further beat
// waiting behind it.
module json_string_escaper (
	input  logic          clk,
	input  logic          arst_n,
	jse_in_if.sink        raw,
	jse_out_if.source     text
);

	// ---------------------------------------------------------------
	// Expansion of the incoming beat (pure combinational)
	// ---------------------------------------------------------------
	function automatic jse_pkg::byte_t hex_char(input logic [3:0] nib);
		if (nib < 4'd10)
			return jse_pkg::CHR_ZERO + {4'h0, nib};
		return jse_pkg::CHR_UPPER_A + {4'h0, nib - 4'd10};
	endfunction

	jse_pkg::byte_t esc [jse_pkg::MAX_OUT];    // escaped body, quote-padded
	logic [2:0]     esc_len;                   // 0 for an empty string, else 1, 2 or 6
	logic           lead_q;                    // opening quote present
	logic           tail_q;                    // closing quote present
	jse_pkg::byte_t seq [jse_pkg::MAX_OUT];
	jse_pkg::idx_t  seq_last;
	logic [3:0]     sum_w;
	logic [3:0]     slot;

	always_comb begin
		jse_pkg::byte_t c;
		c = raw.raw_byte;
		for (int i = 0; i < jse_pkg::MAX_OUT; i++)
			esc[i] = jse_pkg::CHR_QUOTE;
		esc_len = 3'd1;
		if (c == jse_pkg::CHR_QUOTE || c == jse_pkg::CHR_BSLASH) begin
			esc[0]  = jse_pkg::CHR_BSLASH;
			esc[1]  = c;
			esc_len = 3'd2;
		end else if (c >= jse_pkg::PRINT_LO && c <= jse_pkg::PRINT_HI) begin
			esc[0]  = c;
		end else if (c == jse_pkg::CTL_BS || c == jse_pkg::CTL_HT || c == jse_pkg::CTL_LF
				|| c == jse_pkg::CTL_FF || c == jse_pkg::CTL_CR) begin
			esc[0]  = jse_pkg::CHR_BSLASH;
			esc_len = 3'd2;
			case (c)
				jse_pkg::CTL_BS: esc[1] = jse_pkg::CHR_LC_B;
				jse_pkg::CTL_HT: esc[1] = jse_pkg::CHR_LC_T;
				jse_pkg::CTL_LF: esc[1] = jse_pkg::CHR_LC_N;
				jse_pkg::CTL_FF: esc[1] = jse_pkg::CHR_LC_F;
				default:         esc[1] = jse_pkg::CHR_LC_R;
			endcase
		end else begin
			esc[0]  = jse_pkg::CHR_BSLASH;
			esc[1]  = jse_pkg::CHR_LC_U;
			esc[2]  = jse_pkg::CHR_ZERO;
			esc[3]  = jse_pkg::CHR_ZERO;
			esc[4]  = hex_char(c[7:4]);
			esc[5]  = hex_char(c[3:0]);
			esc_len = 3'd6;
		end

		// empty string: both quotes, no body
		lead_q = raw.string_start | raw.string_empty;
		tail_q = raw.string_end | raw.string_empty;
		if (raw.string_empty)
			esc_len = 3'd0;

		// slots beyond the body default to quote, so the closing quote lands
		// right after the body with no extra steering
		for (int i = 0; i < jse_pkg::MAX_OUT; i++) begin
			slot = 4'(i) - {3'b000, lead_q};
			if (lead_q && i == 0)
				seq[i] = jse_pkg::CHR_QUOTE;
			else if (slot < {1'b0, esc_len})
				seq[i] = esc[slot[2:0]];
			else
				seq[i] = jse_pkg::CHR_QUOTE;
		end

		sum_w    = {3'b000, lead_q} + {1'b0, esc_len} + {3'b000, tail_q} - 4'd1;
		seq_last = sum_w[jse_pkg::IDX_W-1:0];
	end

	// ---------------------------------------------------------------
	// Stage 1: expanded beat, drained one byte per cycle while text is not stalled
	// ---------------------------------------------------------------
	jse_pkg::byte_t seq_s1 [jse_pkg::MAX_OUT];
	jse_pkg::idx_t  last_s1;
	jse_pkg::idx_t  idx_s1;
	logic           vld_s1;

	// stage 2: output register
	jse_pkg::byte_t byte_s2;
	logic           last_s2;
	logic           vld_s2;

	logic mv_s1;      // stage 1 hands a byte to stage 2
	logic done_s1;    // that byte is the final one of the beat
	logic acc_in;

	assign mv_s1   = vld_s1 && (!vld_s2 || text.ready);
	assign done_s1 = mv_s1 && (idx_s1 == last_s1);
	assign raw.ready = !vld_s1 || done_s1;
	assign acc_in  = raw.valid && raw.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc_in) begin
			vld_s1 <= 1'b1;
		end else if (done_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			seq_s1  <= seq;
			last_s1 <= seq_last;
			idx_s1  <= '0;
		end else if (mv_s1) begin
			idx_s1  <= idx_s1 + jse_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (mv_s1) begin
			vld_s2 <= 1'b1;
		end else if (text.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			byte_s2 <= seq_s1[idx_s1];
			last_s2 <= (idx_s1 == last_s1);
		end
	end

	assign text.valid    = vld_s2;
	assign text.out_byte = byte_s2;
	assign text.run_last = last_s2;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> idx_s1 <= last_s1)
		else $error("stage 1 index ran past the last byte");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> vld_s1 && idx_s1 == '0)
		else $error("accepted beat not loaded at index zero");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(mv_s1 && !done_s1) |=> vld_s1 && idx_s1 == $past(idx_s1) + jse_pkg::IDX_W'(1))
		else $error("stage 1 index did not advance by one");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!vld_s1 && !vld_s2) |-> raw.ready)
		else $error("empty pipeline refused input");

endmodule

/* verif/json_string_escaper_test.sv */
// Self-checking testbench for json_string_escaper: drives raw string beats and checks
// each escaped text beat against an in-bench escape predictor.
// Depends on jse_pkg, jse_if.sv and the json_string_escaper RTL.
module json_string_escaper_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LONG_HOLD   = 120;  // cycles text.ready is held low in the stall test
	localparam int unsigned TAIL_CYCLES = 24;   // settle time after the last expected beat

	typedef struct packed {
		jse_pkg::byte_t out_byte;
		logic           run_last;
	} text_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hold_go = 1'b0;             // one-cycle request for a long receiver stall
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned mismatches = 0;

	text_beat_t text_due[$];          // escaped bytes still owed by the block, oldest first

	jse_in_if  raw();
	jse_out_if text();

	json_string_escaper uut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.text   (text)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic jse_pkg::byte_t hex_digit(input logic [3:0] nib);
		if (nib < 4'd10)
			return jse_pkg::CHR_ZERO + jse_pkg::byte_t'(nib);
		return jse_pkg::CHR_UPPER_A + jse_pkg::byte_t'(nib) - jse_pkg::byte_t'(10);
	endfunction

	// Expands one raw beat into the text it must produce and queues it.
	function automatic void predict_escape(input jse_pkg::byte_t c, input logic first,
			input logic last, input logic empty);
		jse_pkg::byte_t seq[$];
		text_beat_t     beat;
		if (empty) begin
			// empty string: two quotes, everything else on the beat is ignored
			seq = {seq, jse_pkg::CHR_QUOTE};
			seq = {seq, jse_pkg::CHR_QUOTE};
		end else begin
			if (first)
				seq = {seq, jse_pkg::CHR_QUOTE};
			if (c == jse_pkg::CHR_QUOTE || c == jse_pkg::CHR_BSLASH) begin
				seq = {seq, jse_pkg::CHR_BSLASH};
				seq = {seq, c};
			end else if (c >= jse_pkg::PRINT_LO && c <= jse_pkg::PRINT_HI) begin
				seq = {seq, c};
			end else begin
				seq = {seq, jse_pkg::CHR_BSLASH};
				case (c)
					jse_pkg::CTL_BS: seq = {seq, jse_pkg::CHR_LC_B};
					jse_pkg::CTL_HT: seq = {seq, jse_pkg::CHR_LC_T};
					jse_pkg::CTL_LF: seq = {seq, jse_pkg::CHR_LC_N};
					jse_pkg::CTL_FF: seq = {seq, jse_pkg::CHR_LC_F};
					jse_pkg::CTL_CR: seq = {seq, jse_pkg::CHR_LC_R};
					default: begin
						// \u00XX, upper-case hex
						seq = {seq, jse_pkg::CHR_LC_U};
						seq = {seq, jse_pkg::CHR_ZERO};
						seq = {seq, jse_pkg::CHR_ZERO};
						seq = {seq, hex_digit(c[7:4])};
						seq = {seq, hex_digit(c[3:0])};
					end
				endcase
			end
			if (last)
				seq = {seq, jse_pkg::CHR_QUOTE};
		end
		foreach (seq[i]) begin
			beat.out_byte = seq[i];
			beat.run_last = (i == seq.size() - 1);
			text_due = {text_due, beat};
		end
	endfunction

	// Byte mix biased towards the interesting classes.
	function automatic jse_pkg::byte_t random_text_byte();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)
			return jse_pkg::byte_t'($urandom_range(jse_pkg::PRINT_HI, jse_pkg::PRINT_LO));
		if (pick < 55)
			return $urandom_range(1) ? jse_pkg::CHR_QUOTE : jse_pkg::CHR_BSLASH;
		if (pick < 70) begin
			case ($urandom_range(4))
				0: return jse_pkg::CTL_BS;
				1: return jse_pkg::CTL_HT;
				2: return jse_pkg::CTL_LF;
				3: return jse_pkg::CTL_FF;
				default: return jse_pkg::CTL_CR;
			endcase
		end
		return jse_pkg::byte_t'($urandom);
	endfunction

	// ---------------------------------------------------------------- receiver

	// Random back-pressure on text; a pulse on hold_go starts a long stall that
	// is counted down here.
	initial begin : text_sink
		int unsigned hold_cnt;
		hold_cnt = 0;
		text.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go)
				hold_cnt = LONG_HOLD;
			if (hold_cnt != 0) begin
				hold_cnt--;
				text.ready <= 1'b0;
			end else begin
				text.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Every accepted text beat is matched against the oldest owed byte.
	always @(posedge clk) begin : text_check
		text_beat_t want;
		if (arst_n && text.valid && text.ready) begin
			if (text_due.size() == 0) begin
				$error("unexpected beat: out_byte %h run_last %b", text.out_byte, text.run_last);
				mismatches++;
			end else begin
				want = text_due.pop_front();
				if (text.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, text.out_byte);
					mismatches++;
				end
				if (text.run_last !== want.run_last) begin
					$error("run_last: expected %b, got %b", want.run_last, text.run_last);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sender

	task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
		src_idle_pct <= src_pct;
		sink_idle_pct <= sink_pct;
	endtask

	// Offers one raw beat, waits for the handshake, then maybe idles a while.
	// valid stays high between back-to-back beats.
	task automatic send_beat(input jse_pkg::byte_t b, input logic first, input logic last,
			input logic empty);
		raw.valid <= 1'b1;
		raw.raw_byte <= b;
		raw.string_start <= first;
		raw.string_end <= last;
		raw.string_empty <= empty;
		do
			@(posedge clk);
		while (!raw.ready);
		predict_escape(b, first, last, empty);
		while ($urandom_range(99) < src_idle_pct) begin
			raw.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_text_drained();
		raw.valid <= 1'b0;
		while (text_due.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------- tests

	// Field extremes, every byte class and each framing case.
	task automatic test_directed();
		set_idling(0, 0);
		send_beat(8'h41, 1'b1, 1'b0, 1'b0);          // opening quote + plain byte
		send_beat(8'h00, 1'b0, 1'b0, 1'b0);          // NUL -> \u0000
		send_beat(8'hFF, 1'b0, 1'b0, 1'b0);          // top byte -> \u00FF
		send_beat(8'h7F, 1'b0, 1'b0, 1'b0);          // DEL is not printable
		send_beat(8'h80, 1'b0, 1'b0, 1'b0);
		send_beat(jse_pkg::PRINT_LO, 1'b0, 1'b0, 1'b0);   // printable range edges
		send_beat(jse_pkg::PRINT_HI, 1'b0, 1'b0, 1'b0);
		send_beat(8'h1F, 1'b0, 1'b0, 1'b0);          // just below printable
		send_beat(jse_pkg::CHR_QUOTE, 1'b0, 1'b0, 1'b0);
		send_beat(jse_pkg::CHR_BSLASH, 1'b0, 1'b0, 1'b0);
		send_beat(jse_pkg::CTL_BS, 1'b0, 1'b0, 1'b0);
		send_beat(jse_pkg::CTL_HT, 1'b0, 1'b0, 1'b0);
		send_beat(jse_pkg::CTL_LF, 1'b0, 1'b0, 1'b0);
		send_beat(jse_pkg::CTL_FF, 1'b0, 1'b0, 1'b0);
		send_beat(jse_pkg::CTL_CR, 1'b0, 1'b0, 1'b0);
		send_beat(8'h0B, 1'b0, 1'b0, 1'b0);          // vertical tab has no short escape
		send_beat(8'h7A, 1'b0, 1'b1, 1'b0);          // closing quote
		send_beat(8'hFF, 1'b1, 1'b1, 1'b1);          // empty string, other fields ignored
		send_beat(8'h00, 1'b0, 1'b0, 1'b1);
		send_beat(8'h01, 1'b1, 1'b1, 1'b0);          // one-byte string, longest expansion
		send_beat(8'h78, 1'b1, 1'b1, 1'b0);          // one-byte plain string
		send_beat(jse_pkg::CTL_LF, 1'b1, 1'b0, 1'b0);
		send_beat(jse_pkg::CHR_QUOTE, 1'b0, 1'b1, 1'b0);
	endtask

	// Mostly well-formed strings with random content, some broken framing and noise.
	task automatic test_strings(input int unsigned n_items);
		int unsigned sent;
		int unsigned kind;
		int unsigned len;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(99);
			if (kind < 8) begin
				send_beat(jse_pkg::byte_t'($urandom), 1'($urandom), 1'($urandom),
					1'($urandom_range(3) == 0));
				sent++;
			end else if (kind < 16) begin
				len = $urandom_range(6, 1);
				for (int unsigned i = 0; i < len; i++)
					send_beat(random_text_byte(), 1'($urandom_range(4) == 0),
						1'($urandom_range(4) == 0), 1'b0);
				sent += len;
			end else begin
				len = $urandom_range(9);
				if (len == 0) begin
					send_beat(jse_pkg::byte_t'($urandom), 1'($urandom), 1'($urandom), 1'b1);
					sent++;
				end else begin
					for (int unsigned i = 0; i < len; i++)
						send_beat(random_text_byte(), i == 0, i == len - 1, 1'b0);
					sent += len;
				end
			end
		end
	endtask

	// Receiver stalls for a long stretch while the sender keeps offering
	// escape-heavy beats, so the block backs up onto raw.ready.
	task automatic test_long_stall();
		set_idling(0, 0);
		raw.valid <= 1'b0;
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		for (int unsigned i = 0; i < 24; i++)
			send_beat(random_text_byte(), i == 0, i == 23, 1'b0);
	endtask

	// Sender waits for the block to drain completely, then resumes.
	task automatic test_drain_pause();
		set_idling(0, 20);
		send_beat(8'h01, 1'b1, 1'b0, 1'b0);
		send_beat(jse_pkg::CHR_BSLASH, 1'b0, 1'b1, 1'b0);
		wait_text_drained();
		send_beat(8'hC3, 1'b1, 1'b1, 1'b0);
		send_beat(8'h20, 1'b0, 1'b0, 1'b1);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		raw.valid = 1'b0;
		raw.raw_byte = '0;
		raw.string_start = 1'b0;
		raw.string_end = 1'b0;
		raw.string_empty = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		set_idling(14, 86);
		test_strings(115);
		set_idling(86, 14);
		test_strings(115);
		set_idling(0, 0);
		test_strings(115);
		test_long_stall();
		test_drain_pause();

		wait_text_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && text_due.size() == 0)
			$display("json_string_escaper test passed");
		else
			$display("json_string_escaper test failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10ms;
		$display("json_string_escaper test failed");
		$finish;
	end

endmodule
